// File: src/indexed_sequence_store_unit_macros.svh
// ----------------------------------------------------------------------------
// Indexed sequence store assertion macros
// Shared concurrent assertion forms used by the indexed sequence store unit.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: src/iss_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Sizes, operation and status codes, and the command and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_READ      = 3'd0;
  localparam mode_t MODE_INS_FRONT = 3'd1;
  localparam mode_t MODE_APPEND    = 3'd2;
  localparam mode_t MODE_INS_AT    = 3'd3;
  localparam mode_t MODE_DELETE    = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_POS = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    PTR_POS,
    PTR_TOP,
    PTR_NEXT
  } ptr_sel_t;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_ONES,
    RV_MEM
  } rv_sel_t;

  typedef struct packed {
    logic     load;
    logic     set_ptr;
    ptr_sel_t ptr_sel;
    logic     dir_up;
    logic     rd;
    logic     wr_shift;
    logic     wr_value;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     result;
    rv_sel_t  rv_sel;
    status_t  res_status;
  } iss_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  pos_lt_cnt;
    logic  pos_le_cnt;
    logic  ins_at_end;
    logic  del_at_end;
    logic  ptr_end;
    logic  pend;
  } iss_flags_t;

endpackage

// File: src/iss_datapath.sv
// ----------------------------------------------------------------------------
// Indexed sequence store datapath
// Element memory, count, shift pointer and result registers.
// ----------------------------------------------------------------------------
module iss_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  iss_pkg::iss_cmd_t                    cmd,
  input  iss_pkg::mode_t                       mode,
  input  logic [iss_pkg::POS_W-1:0]            position,
  input  logic signed [iss_pkg::DATA_W-1:0]    data_value,
  output iss_pkg::iss_flags_t                  flags,
  output logic signed [iss_pkg::DATA_W-1:0]    read_value,
  output iss_pkg::status_t                     status,
  output logic [iss_pkg::POS_W-1:0]            element_count
);
  import iss_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  mode_t                  mode_q;
  logic [POS_W-1:0]       pos_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ADDR_W-1:0]      ptr;
  logic [ADDR_W-1:0]      src_q;
  logic                   pend;
  logic [VALUE_WIDTH-1:0] rdata;

  logic signed [DATA_W-1:0] read_value_q;
  status_t                  status_q;
  logic [POS_W-1:0]         count_q;

  logic signed [63:0]  value_ext;
  logic [63:0]         rdata_ext;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    cnt_c;
  logic [CMP_W-1:0]    ins_pos;
  logic [ADDR_W-1:0]   ins_addr;
  logic [ADDR_W-1:0]   pos_addr;
  logic [ADDR_W-1:0]   top_addr;
  logic [ADDR_W-1:0]   wr_addr;

  always_comb begin
    value_ext = 64'(data_value);
    rdata_ext = 64'(rdata);
    pos_c     = CMP_W'(pos_q);
    cnt_c     = CMP_W'(count);
    unique case (mode_q)
      MODE_INS_FRONT: ins_pos = '0;
      MODE_APPEND:    ins_pos = cnt_c;
      default:        ins_pos = pos_c;
    endcase
    ins_addr = ADDR_W'(ins_pos);
    pos_addr = ADDR_W'(pos_q);
    top_addr = ADDR_W'(count - CNT_W'(1));
    wr_addr  = cmd.dir_up ? (src_q + ADDR_W'(1)) : (src_q - ADDR_W'(1));

    if (cmd.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end

    flags.mode       = mode_q;
    flags.full       = (count == CNT_W'(CAPACITY));
    flags.pos_lt_cnt = (pos_c < cnt_c);
    flags.pos_le_cnt = (pos_c <= cnt_c);
    flags.ins_at_end = (ins_pos == cnt_c);
    flags.del_at_end = ((pos_c + CMP_W'(1)) == cnt_c);
    flags.ptr_end    = cmd.dir_up ? (ptr == ins_addr) : (ptr == top_addr);
    flags.pend       = pend;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.rd) begin
        pend <= 1'b1;
      end else if (cmd.wr_shift) begin
        pend <= 1'b0;
      end
    end
  end

  // Request hold, pointer and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      pos_q   <= position;
      value_q <= VALUE_WIDTH'(value_ext);
    end
    if (cmd.set_ptr) begin
      unique case (cmd.ptr_sel)
        PTR_TOP:  ptr <= top_addr;
        PTR_NEXT: ptr <= pos_addr + ADDR_W'(1);
        default:  ptr <= pos_addr;
      endcase
    end else if (cmd.rd) begin
      ptr   <= cmd.dir_up ? (ptr - ADDR_W'(1)) : (ptr + ADDR_W'(1));
      src_q <= ptr;
    end
    if (cmd.result) begin
      unique case (cmd.rv_sel)
        RV_MEM:  read_value_q <= DATA_W'(rdata_ext);
        RV_ONES: read_value_q <= '1;
        default: read_value_q <= '0;
      endcase
      status_q <= cmd.res_status;
      count_q  <= POS_W'(count_next);
    end
  end

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[wr_addr] <= rdata;
    end else if (cmd.wr_value) begin
      mem[ins_addr] <= value_q;
    end
    if (cmd.rd) begin
      rdata <= mem[ptr];
    end
  end

  assign read_value    = read_value_q;
  assign status        = status_q;
  assign element_count = count_q;

endmodule

// File: src/iss_controller.sv
// ----------------------------------------------------------------------------
// Indexed sequence store controller
// Decodes a request and sequences reads, shifts and the final update.
// ----------------------------------------------------------------------------
module iss_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  iss_pkg::iss_flags_t flags,
  output iss_pkg::iss_cmd_t   cmd,
  output logic                busy,
  output logic                done
);
  import iss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SHIFT,
    S_DRAIN,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_READ,
    K_INS,
    K_DEL
  } kind_t;

  state_t  state, state_next;
  kind_t   kind, kind_next;
  status_t res_status, res_status_next;
  rv_sel_t rv_sel, rv_sel_next;
  logic    done_next;

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    res_status_next = res_status;
    rv_sel_next     = rv_sel;
    done_next       = 1'b0;

    cmd            = '0;
    cmd.ptr_sel    = PTR_POS;
    cmd.dir_up     = (kind == K_INS);
    cmd.rv_sel     = rv_sel;
    cmd.res_status = res_status;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        kind_next       = K_NONE;
        rv_sel_next     = RV_ZERO;
        res_status_next = ST_BAD_POS;
        state_next      = S_FINAL;
        unique case (flags.mode)
          MODE_READ: begin
            if (flags.pos_lt_cnt) begin
              kind_next       = K_READ;
              rv_sel_next     = RV_MEM;
              res_status_next = ST_OK;
              cmd.set_ptr     = 1'b1;
              cmd.ptr_sel     = PTR_POS;
              state_next      = S_READ;
            end else begin
              rv_sel_next = RV_ONES;
            end
          end
          MODE_INS_FRONT, MODE_APPEND, MODE_INS_AT: begin
            if ((flags.mode == MODE_INS_AT) && !flags.pos_le_cnt) begin
              res_status_next = ST_BAD_POS;
            end else if (flags.full) begin
              res_status_next = ST_FULL;
            end else begin
              kind_next       = K_INS;
              res_status_next = ST_OK;
              if (!flags.ins_at_end) begin
                cmd.set_ptr = 1'b1;
                cmd.ptr_sel = PTR_TOP;
                state_next  = S_SHIFT;
              end
            end
          end
          MODE_DELETE: begin
            if (flags.pos_lt_cnt) begin
              kind_next       = K_DEL;
              res_status_next = ST_OK;
              if (!flags.del_at_end) begin
                cmd.set_ptr = 1'b1;
                cmd.ptr_sel = PTR_NEXT;
                state_next  = S_SHIFT;
              end
            end
          end
          default: begin
            res_status_next = ST_BAD_POS;
          end
        endcase
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_FINAL;
      end
      S_SHIFT: begin
        cmd.rd       = 1'b1;
        cmd.wr_shift = flags.pend;
        if (flags.ptr_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_FINAL;
      end
      S_FINAL: begin
        cmd.result   = 1'b1;
        cmd.wr_value = (kind == K_INS);
        cmd.cnt_inc  = (kind == K_INS);
        cmd.cnt_dec  = (kind == K_DEL);
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_NONE;
      res_status <= ST_OK;
      rv_sel     <= RV_ZERO;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      kind       <= kind_next;
      res_status <= res_status_next;
      rv_sel     <= rv_sel_next;
      done       <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: src/indexed_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// Indexed sequence store unit
// Ordered store of signed values with read, insert and delete by position.
// ----------------------------------------------------------------------------
// A request transfers at the rising edge where start is high and busy is low.
// Its result appears for exactly one cycle with done high and must be taken
// in that cycle, since the receiver has no way to stall it. Busy is already
// low in the done cycle, so the next request may transfer there. A rejected
// request, an append or a delete of the last element goes from decode
// straight to the final update; a read passes through one memory read; an
// insert or delete that moves stored elements passes through the shift.
// The shift is paced by the element memory, which has one write port and
// one read port: it moves one element per cycle through a registered read
// and a write in the following cycle.
// ----------------------------------------------------------------------------
module indexed_sequence_store_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [iss_pkg::MODE_W-1:0]        mode,
  input  logic [iss_pkg::POS_W-1:0]         position,
  input  logic signed [iss_pkg::DATA_W-1:0] data_value,
  output logic                              done,
  output logic signed [iss_pkg::DATA_W-1:0] read_value,
  output logic [iss_pkg::STATUS_W-1:0]      status,
  output logic [iss_pkg::POS_W-1:0]         element_count
);
  import iss_pkg::*;

`include "indexed_sequence_store_unit_macros.svh"

  // Commands flow from the controller to the datapath, status flags back.
  iss_cmd_t   cmd;
  iss_flags_t flags;

  // The controller owns sequencing: it decodes the held request, chooses
  // between a direct update and an element shift, and raises done in the
  // same cycle in which the result registers first show the new result.
  iss_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the element memory, the element count, the shift
  // pointer and the registered result fields that drive the output ports.
  iss_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .position      (position),
    .data_value    (data_value),
    .flags         (flags),
    .read_value    (read_value),
    .status        (status),
    .element_count (element_count)
  );

  // A result is only ever presented while the unit is idle.
  `ISS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // An accepted request always makes the unit busy in the next cycle.
  `ISS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // The result strobe never lasts more than one cycle.
  `ISS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // A dropped insert is reported only with the store at capacity.
  `ISS_ASSERT_SAME(a_full_count, clk, rst, done && (status == ST_FULL),
                   element_count == POS_W'(CAPACITY))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed sequence store unit testbench
// Drives a directed sequence and random bursts of read, insert and delete
// requests, predicts every result from a behavioral copy of the ordered
// store, and checks each result field by field as it completes.
// ----------------------------------------------------------------------------
module tb;
  import iss_pkg::*;

  // Every mode code above delete is unused and must be rejected.
  localparam int MODE_CODES = 1 << MODE_W;
  localparam int POS_MAX = (1 << POS_W) - 1;
  // The limit is many times the longest request and the longest sender gap.
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 16;
  localparam int RANDOM_ITEMS = 830;

  typedef struct {
    mode_t             op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    bit                wait_idle;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
    logic [POS_W-1:0]  count;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [MODE_W-1:0]          mode = '0;
  logic [POS_W-1:0]           position = '0;
  logic signed [DATA_W-1:0]   data_value = '0;
  logic                       done;
  logic signed [DATA_W-1:0]   read_value;
  logic [STATUS_W-1:0]        status;
  logic [POS_W-1:0]           element_count;

  request_t     pending_requests[$];
  list_result_t expected_results[$];

  // Behavioral copy of the store, advanced on every accepted transfer.
  logic [DATA_W-1:0] list_values[CAPACITY];
  int                list_len = 0;

  // Element count the generator expects at the point in the stream it has
  // reached, so that positions can be aimed at the live part of the list.
  int planned_len = 0;

  logic took_request = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   error_count = 0;
  int   idle_cycles = 0;

  indexed_sequence_store_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .position      (position),
    .data_value    (data_value),
    .done          (done),
    .read_value    (read_value),
    .status        (status),
    .element_count (element_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Opens a hole at slot and stores the value there; a full list refuses.
  task automatic insert_value(input int slot, input logic [DATA_W-1:0] value,
                              output status_t st);
    if (list_len >= CAPACITY) begin
      st = ST_FULL;
    end else begin
      for (int i = list_len; i > slot; i--) list_values[i] = list_values[i-1];
      list_values[slot] = value;
      list_len++;
      st = ST_OK;
    end
  endtask

  task automatic predict_response(input mode_t op, input logic [POS_W-1:0] pos,
                                  input logic [DATA_W-1:0] value,
                                  output list_result_t res);
    res.read_value = '0;
    res.status = ST_OK;
    case (op)
      MODE_READ: begin
        if (pos < list_len) begin
          res.read_value = list_values[pos];
        end else begin
          res.read_value = '1;
          res.status = ST_BAD_POS;
        end
      end
      MODE_INS_FRONT: insert_value(0, value, res.status);
      MODE_APPEND: insert_value(list_len, value, res.status);
      MODE_INS_AT: begin
        // A bad position wins over a full list.
        if (pos > list_len) res.status = ST_BAD_POS;
        else insert_value(pos, value, res.status);
      end
      MODE_DELETE: begin
        if (pos >= list_len) begin
          res.status = ST_BAD_POS;
        end else begin
          for (int i = pos; i < list_len - 1; i++) list_values[i] = list_values[i+1];
          list_len--;
        end
      end
      default: res.status = ST_BAD_POS;
    endcase
    res.count = list_len[POS_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_request(input mode_t op, input int pos,
                              input logic [DATA_W-1:0] value);
    request_t req;
    req.op = op;
    req.pos = pos[POS_W-1:0];
    req.value = value;
    req.wait_idle = 1'b0;
    pending_requests.push_back(req);
    case (op)
      MODE_INS_FRONT, MODE_APPEND: if (planned_len < CAPACITY) planned_len++;
      MODE_INS_AT: if (pos <= planned_len && planned_len < CAPACITY) planned_len++;
      MODE_DELETE: if (pos < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  // A marker that makes the driver hold off until every result is back.
  task automatic push_drain();
    request_t req;
    req.op = MODE_READ;
    req.pos = '0;
    req.value = '0;
    req.wait_idle = 1'b1;
    pending_requests.push_back(req);
  endtask

  // Positions mostly land inside the list or on its ends; some are anywhere
  // in the field's range to hit the rejection paths.
  function automatic int pick_position(input int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $urandom_range(0, POS_MAX);
    if (roll == 1) return span;
    if (roll == 2 && span > 0) return span - 1;
    return $urandom_range(0, span);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return '1;
      default: return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int           made;
    int           trend;
    int           seg_len;
    int           ins_pct;
    int           roll;
    int           live_span;
    mode_t        op;

    // Directed part. Starting from an empty list: every rejection on an
    // empty list, each insert flavor with the value extremes, reads over the
    // whole list and one past it, the all-ones position for every
    // positional mode, deletes in the middle, at the end and at the front,
    // and the unused mode codes.
    push_request(MODE_READ, 0, '0);
    push_request(MODE_DELETE, 0, '0);
    push_request(MODE_INS_AT, 1, 32'h1234_5678);
    push_request(MODE_INS_AT, 0, 32'h7FFF_FFFF);
    push_request(MODE_INS_FRONT, 0, 32'h8000_0000);
    push_request(MODE_APPEND, 0, 32'hFFFF_FFFF);
    push_request(MODE_INS_AT, 3, 32'h0000_0000);
    push_request(MODE_INS_AT, 1, 32'h5A5A_A5A5);
    for (int i = 0; i <= 5; i++) push_request(MODE_READ, i, '0);
    push_request(MODE_READ, POS_MAX, '0);
    push_request(MODE_INS_AT, POS_MAX, 32'hDEAD_BEEF);
    push_request(MODE_DELETE, POS_MAX, '0);
    push_request(MODE_DELETE, 2, '0);
    push_request(MODE_DELETE, 3, '0);
    push_request(MODE_DELETE, 0, '0);
    for (int m = MODE_DELETE + 1; m < MODE_CODES; m++) push_request(mode_t'(m), POS_MAX, '1);
    push_request(MODE_READ, 0, '0);
    push_request(MODE_READ, 1, '0);
    push_drain();

    // Random part in segments that lean toward growing, shrinking or
    // neither, so the list is driven to full and back to empty many times.
    // Unused mode codes are noise and do not count toward the total.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      trend = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 90);
      ins_pct = (trend == 0) ? 75 : (trend == 1) ? 20 : 45;
      for (int k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        live_span = (planned_len > 0) ? planned_len - 1 : 0;
        if (roll < ins_pct) begin
          case ($urandom_range(0, 2))
            0: op = MODE_INS_FRONT;
            1: op = MODE_APPEND;
            default: op = MODE_INS_AT;
          endcase
          push_request(op, pick_position(planned_len), pick_value());
          made++;
        end else begin
          roll = $urandom_range(0, 9);
          if (roll < 5) begin
            push_request(MODE_DELETE, pick_position(live_span), pick_value());
            made++;
          end else if (roll < 9) begin
            push_request(MODE_READ, pick_position(live_span), pick_value());
            made++;
          end else begin
            push_request(mode_t'($urandom_range(MODE_DELETE + 1, MODE_CODES - 1)),
                         $urandom_range(0, POS_MAX), pick_value());
          end
        end
      end
      if ($urandom_range(0, 5) == 0) push_drain();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every transfer has one result, so an empty expectation queue with no
    // request on the bus means the block has nothing left in flight.
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    // Quiet period to catch a stray completion strobe.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never completed", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // Requests change on the falling edge. A request stays on the bus until the
  // rising edge at which busy was low takes it. Between bursts the sender
  // idles for a random gap, and a drain marker holds it off until the block
  // has returned every result.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_request) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0 && pending_requests[0].wait_idle) begin
        start <= 1'b0;
        if (expected_results.size() == 0) void'(pending_requests.pop_front());
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        start <= 1'b1;
        mode <= nxt.op;
        position <= nxt.pos;
        data_value <= nxt.value;
        if (burst_left <= 1) begin
          // Most gaps are short, so requests often wait for busy to fall and
          // transfer back to back; some are long enough to let the block idle.
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90)
                                                  : $urandom_range(0, 2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // All sampling happens on the rising edge, against values that were
  // settled before it. A completion is checked before a new transfer is
  // predicted; the order does not matter, since no result can complete in
  // the cycle its own request transfers.
  always @(posedge clk) begin : watch_results
    list_result_t want;
    if (rst) begin
      took_request <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("done asserted with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, read_value);
          check_field("status", DATA_W'(want.status), DATA_W'(status));
          check_field("element_count", DATA_W'(want.count), DATA_W'(element_count));
        end
      end
      took_request <= start && !busy;
      if (start && !busy) begin
        predict_response(mode_t'(mode), position, data_value, want);
        expected_results.push_back(want);
      end
      // Watchdog: any transfer in either direction counts as progress.
      if (done || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

endmodule
